FILE: rtl/servo_sweep_pwm_assert.svh
// assertion macros for the servo sweep pwm block
// no dependencies, included by the top level
`ifndef SERVO_SWEEP_PWM_ASSERT_SVH
`define SERVO_SWEEP_PWM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ssp_pkg.sv
// shared types and constants for the servo sweep pwm block
// no dependencies
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int unsigned VAL_W = 16;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [VAL_W-1:0] RST_PERIOD_TOP = 16'd21352;
    localparam logic [VAL_W-1:0] RST_WIDTH_MIN = 16'd1068;
    localparam logic [VAL_W-1:0] RST_WIDTH_MAX = 16'd2135;
    localparam logic [VAL_W-1:0] RST_DELAY_LOW = 16'd500;
    localparam logic [VAL_W-1:0] RST_DELAY_HIGH = 16'd5000;
    localparam logic [VAL_W-1:0] RST_DELAY_STEP = 16'd500;
    localparam logic [VAL_W-1:0] RST_DELAY_NOW = 16'd500;

    typedef enum logic [ADDR_W-1:0] {
        REG_PERIOD_TOP = 3'd0,
        REG_WIDTH_MIN  = 3'd1,
        REG_WIDTH_MAX  = 3'd2,
        REG_DELAY_LOW  = 3'd3,
        REG_DELAY_HIGH = 3'd4,
        REG_DELAY_STEP = 3'd5
    } ssp_reg_t;

    typedef struct packed {
        logic             sweeping_up;
        logic [VAL_W-1:0] step_delay;
        logic [VAL_W-1:0] pulse_width;
        logic             pwm_level;
    } ssp_result_t;

endpackage

FILE: rtl/ssp_core.sv
// configuration registers, sweep state and per-tick update logic
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ssp_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [ssp_pkg::VAL_W-1:0]  cfg_wdata,
    input  logic                       tick,
    input  logic                       dir_press,
    input  logic                       speed_press,
    output ssp_pkg::ssp_result_t       result
);

    logic [ssp_pkg::VAL_W-1:0] period_top_reg, width_min_reg, width_max_reg;
    logic [ssp_pkg::VAL_W-1:0] delay_low_reg, delay_high_reg, delay_step_reg;

    logic [ssp_pkg::VAL_W-1:0] period_count_reg, period_count_next;
    logic [ssp_pkg::VAL_W-1:0] width_now_reg, width_now_next;
    logic [ssp_pkg::VAL_W-1:0] delay_now_reg, delay_now_next;
    logic [ssp_pkg::VAL_W-1:0] wait_count_reg, wait_count_next;
    logic                      going_up_reg, going_up_next;
    logic                      delay_rising_reg, delay_rising_next;

    logic                      going_mid;
    logic signed [17:0]        delay_sum;
    logic                      step_due;
    logic [16:0]               width_inc;
    logic signed [17:0]        width_dec;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_top_reg <= ssp_pkg::RST_PERIOD_TOP;
            width_min_reg  <= ssp_pkg::RST_WIDTH_MIN;
            width_max_reg  <= ssp_pkg::RST_WIDTH_MAX;
            delay_low_reg  <= ssp_pkg::RST_DELAY_LOW;
            delay_high_reg <= ssp_pkg::RST_DELAY_HIGH;
            delay_step_reg <= ssp_pkg::RST_DELAY_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ssp_pkg::REG_PERIOD_TOP: period_top_reg <= cfg_wdata;
                ssp_pkg::REG_WIDTH_MIN:  width_min_reg  <= cfg_wdata;
                ssp_pkg::REG_WIDTH_MAX:  width_max_reg  <= cfg_wdata;
                ssp_pkg::REG_DELAY_LOW:  delay_low_reg  <= cfg_wdata;
                ssp_pkg::REG_DELAY_HIGH: delay_high_reg <= cfg_wdata;
                ssp_pkg::REG_DELAY_STEP: delay_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        going_mid = going_up_reg ^ dir_press;

        // step delay change on speed press
        delay_now_next    = delay_now_reg;
        delay_rising_next = delay_rising_reg;
        if (delay_rising_reg) begin
            delay_sum = $signed({2'b00, delay_now_reg}) + $signed({2'b00, delay_step_reg});
        end else begin
            delay_sum = $signed({2'b00, delay_now_reg}) - $signed({2'b00, delay_step_reg});
        end
        if (speed_press) begin
            if (delay_sum >= $signed({2'b00, delay_high_reg})) begin
                delay_now_next    = delay_high_reg;
                delay_rising_next = 1'b0;
            end else if (delay_sum <= $signed({2'b00, delay_low_reg})) begin
                delay_now_next    = delay_low_reg;
                delay_rising_next = 1'b1;
            end else begin
                delay_now_next = delay_sum[ssp_pkg::VAL_W-1:0];
            end
        end

        // sweep step when the wait is over
        step_due        = wait_count_reg >= delay_now_next;
        wait_count_next = step_due ? '0 : wait_count_reg + 16'd1;
        width_inc       = {1'b0, width_now_reg} + 17'd1;
        width_dec       = $signed({2'b00, width_now_reg}) - 18'sd1;
        width_now_next  = width_now_reg;
        going_up_next   = going_mid;
        if (step_due) begin
            if (going_mid) begin
                if (width_inc >= {1'b0, width_max_reg}) begin
                    width_now_next = width_max_reg;
                    going_up_next  = 1'b0;
                end else begin
                    width_now_next = width_inc[ssp_pkg::VAL_W-1:0];
                end
            end else begin
                if (width_dec <= $signed({2'b00, width_min_reg})) begin
                    width_now_next = width_min_reg;
                    going_up_next  = 1'b1;
                end else begin
                    width_now_next = width_dec[ssp_pkg::VAL_W-1:0];
                end
            end
        end

        period_count_next = (period_count_reg >= period_top_reg) ? '0
                                                                  : period_count_reg + 16'd1;

        result.pwm_level   = period_count_reg < width_now_next;
        result.pulse_width = width_now_next;
        result.step_delay  = delay_now_next;
        result.sweeping_up = going_up_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= '0;
            width_now_reg    <= ssp_pkg::RST_WIDTH_MIN;
            going_up_reg     <= 1'b1;
            delay_now_reg    <= ssp_pkg::RST_DELAY_NOW;
            delay_rising_reg <= 1'b1;
            wait_count_reg   <= '0;
        end else if (tick) begin
            period_count_reg <= period_count_next;
            width_now_reg    <= width_now_next;
            going_up_reg     <= going_up_next;
            delay_now_reg    <= delay_now_next;
            delay_rising_reg <= delay_rising_next;
            wait_count_reg   <= wait_count_next;
        end
    end

endmodule

FILE: rtl/servo_sweep_pwm.sv
// Servo PWM generator with a self-sweeping pulse width. Each input item is one
// timer tick; one result item per tick goes to the result register, and a new
// item is taken every cycle while s_tready is high. The whole tick update runs
// between the sweep state registers and the result register; a skid register
// behind the result register keeps s_tready registered, so a stall on the
// result side costs at most one extra item of buffering before s_tready drops.
// depends on ssp_pkg, ssp_core and servo_sweep_pwm_assert.svh
`timescale 1ns / 1ps
`include "servo_sweep_pwm_assert.svh"

module servo_sweep_pwm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ssp_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [ssp_pkg::VAL_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // dir_press, speed_press, zero pad
    input  logic [ssp_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // pwm_level, pulse_width, step_delay, sweeping_up, zero pad
    output logic [ssp_pkg::M_DATA_W-1:0] m_tdata
);

    logic                 accept;
    ssp_pkg::ssp_result_t core_res;
    ssp_pkg::ssp_result_t out_reg, out_next, skid_reg, skid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    assign accept = s_tvalid && s_tready;

    ssp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .tick        (accept),
        .dir_press   (s_tdata[0]),
        .speed_press (s_tdata[1]),
        .result      (core_res)
    );

    // output register with skid
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next       = skid_reg;
                out_valid_next = 1'b1;
            end else begin
                out_next       = core_res;
                out_valid_next = accept;
            end
            skid_valid_next = 1'b0;
        end else if (accept) begin
            skid_next       = core_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    `SSP_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `SSP_ASSERT_NEXT(a_skid_fill_on_stall, aclk, aresetn,
        accept && out_valid_reg && !m_tready, skid_valid_reg)
    `SSP_ASSERT_NEXT(a_skid_drain, aclk, aresetn,
        skid_valid_reg && m_tready, !skid_valid_reg && out_valid_reg)

endmodule
